// ===== src/modbus_rtu_response_checker_assert.svh =====
// ---------------------------------------------------------------------------
// Modbus RTU response checker assertion macros
// Shorthand for the concurrent checks used inside the checker's RTL.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// Checks a property on every rising clock edge while reset is released.
`define MRC_ASSERT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define MRC_ASSERT_ALWAYS(label, clock, prop, msg) \
    label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== src/mrc_pkg.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU response checker package
// Item types, register map, status codes and the CRC-16/MODBUS byte update.
// ---------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

    // Default for the largest read reply the checker will size a frame for.
    localparam int MAX_READ_REGS_DEF = 125;

    // Register map, indexed by paddr[3:2].
    localparam logic [1:0] REG_EXPECTED_SLAVE    = 2'd0;
    localparam logic [1:0] REG_TRANSACTION_TYPE  = 2'd1;
    localparam logic [1:0] REG_EXPECTED_COUNT    = 2'd2;
    localparam logic [1:0] REG_EXPECTED_OFFSET   = 2'd3;

    // Frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXCEPTION = 3'd1;
    localparam logic [2:0] ST_CRC       = 3'd2;
    localparam logic [2:0] ST_ADDRESS   = 3'd3;
    localparam logic [2:0] ST_FUNCTION  = 3'd4;
    localparam logic [2:0] ST_COUNT     = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;

    // Result kinds.
    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;

    // Function codes and masks.
    localparam logic [7:0]  FC_READ    = 8'h03;
    localparam logic [7:0]  FC_WRITE   = 8'h10;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Mismatch flag bit positions.
    localparam int FLAG_ADDR  = 0;
    localparam int FLAG_FUNC  = 1;
    localparam int FLAG_COUNT = 2;
    localparam int FLAG_RANGE = 3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic [7:0]  exception_code;
    } out_item_t;

    // One byte of the reflected CRC-16/MODBUS update.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/modbus_rtu_response_checker.sv =====
// ---------------------------------------------------------------------------
// Modbus RTU response checker
// Checks a slave reply byte by byte against the awaited request.
// ---------------------------------------------------------------------------
// Each item is one received byte of a Modbus RTU slave reply, with
// frame_start marking the first byte. The checker runs a CRC-16/MODBUS over
// the frame, emits every big-endian register of a read-holding-registers
// reply as a provisional result as soon as its low byte arrives, and after
// the second CRC byte emits one final status (priority: CRC error, exception,
// address, function, byte count, write range). Frame length follows the
// registers: 5 bytes for an exception reply (function code bit 7 set),
// 5 + 2N for a read of N registers, 8 for a write-multiple echo. A byte with
// frame_start low while no frame is open is dropped without a result, and a
// new frame_start abandons an open frame silently. Throughput is one item per
// clock unless a held result stalls: the whole per-byte step, including the
// eight-bit CRC update, sits between the input stage register and the result
// register, which takes the stage item's result as it moves on. Only a result
// held by out_stall back-pressures the input. Registers are to be written via the
// APB-style port only while no item is in flight (the block does not enforce
// this); a change made while a frame is open applies from its next byte on.
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker #(
    parameter int MAX_READ_REGS = mrc_pkg::MAX_READ_REGS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,

    input  wire                 in_valid,
    output logic                in_stall,
    input  mrc_pkg::in_item_t   in_data,

    output logic                out_valid,
    input  wire                 out_stall,
    output mrc_pkg::out_item_t  out_data,

    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [6:0] MaxRegs = 7'(MAX_READ_REGS);

    // Configuration registers.
    logic [7:0]  expected_slave_reg;
    logic        transaction_type_reg;
    logic [6:0]  expected_count_reg;
    logic [15:0] expected_offset_reg;
    logic        cfg_write;

    // Input stage.
    logic              stage_valid_reg;
    mrc_pkg::in_item_t stage_item_reg;
    logic              stage_adv;
    logic              stage_fire;

    // Frame state.
    logic [7:0]  byte_pos_reg,  byte_pos_next;
    logic [15:0] crc_reg,       crc_next;
    logic        exc_seen_reg,  exc_seen_next;
    logic [3:0]  flags_reg,     flags_next;
    logic [7:0]  held_reg,      held_next;
    logic [7:0]  exc_byte_reg,  exc_byte_next;
    logic [7:0]  crc_low_reg,   crc_low_next;

    // Step logic.
    logic               frame_open;
    logic [7:0]         rx;
    logic [7:0]         p;
    logic [6:0]         nreg;
    logic [7:0]         frame_len;
    logic [8:0]         p_plus2;
    logic [7:0]         d;
    logic [2:0]         final_status;
    logic               emit;
    mrc_pkg::out_item_t result;

    // Result register.
    logic               out_valid_reg;
    mrc_pkg::out_item_t out_data_reg;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_slave_reg   <= 8'd1;
            transaction_type_reg <= 1'b0;
            expected_count_reg   <= 7'd1;
            expected_offset_reg  <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                mrc_pkg::REG_EXPECTED_SLAVE:   expected_slave_reg   <= pwdata[7:0];
                mrc_pkg::REG_TRANSACTION_TYPE: transaction_type_reg <= pwdata[0];
                mrc_pkg::REG_EXPECTED_COUNT:   expected_count_reg   <= pwdata[6:0];
                mrc_pkg::REG_EXPECTED_OFFSET:  expected_offset_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mrc_pkg::REG_EXPECTED_SLAVE:   prdata = {24'd0, expected_slave_reg};
            mrc_pkg::REG_TRANSACTION_TYPE: prdata = {31'd0, transaction_type_reg};
            mrc_pkg::REG_EXPECTED_COUNT:   prdata = {25'd0, expected_count_reg};
            mrc_pkg::REG_EXPECTED_OFFSET:  prdata = {16'd0, expected_offset_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Handshake: the stage item moves on unless it makes a result that
    // cannot enter the result register this cycle.
    // ---------------------------------------------------------------------
    assign stage_adv  = !emit || !out_valid_reg || !out_stall;
    assign stage_fire = stage_valid_reg && stage_adv;
    assign in_stall   = stage_valid_reg && !stage_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_fire)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_item_reg <= in_data;
        end
    end

    // ---------------------------------------------------------------------
    // Per-byte step. A frame start first clears the frame state, so all
    // decisions below work on the cleared values in that case.
    // ---------------------------------------------------------------------
    always_comb
    begin
        rx         = stage_item_reg.rx_byte;
        frame_open = stage_item_reg.frame_start || (byte_pos_reg != 8'd0);

        if (stage_item_reg.frame_start)
        begin
            p             = 8'd0;
            crc_next      = mrc_pkg::CRC_INIT;
            exc_seen_next = 1'b0;
            flags_next    = 4'd0;
            held_next     = 8'd0;
            exc_byte_next = 8'd0;
            crc_low_next  = 8'd0;
        end
        else
        begin
            p             = byte_pos_reg;
            crc_next      = crc_reg;
            exc_seen_next = exc_seen_reg;
            flags_next    = flags_reg;
            held_next     = held_reg;
            exc_byte_next = exc_byte_reg;
            crc_low_next  = crc_low_reg;
        end
        byte_pos_next = byte_pos_reg;

        nreg = (expected_count_reg > MaxRegs) ? MaxRegs : expected_count_reg;

        if (p == 8'd1 && rx[7])
        begin
            exc_seen_next = 1'b1;
        end

        if (exc_seen_next)
        begin
            frame_len = 8'd5;
        end
        else if (transaction_type_reg)
        begin
            frame_len = 8'd8;
        end
        else
        begin
            frame_len = 8'd5 + {nreg, 1'b0};
        end

        p_plus2 = {1'b0, p} + 9'd2;
        d       = p - 8'd3;
        emit    = 1'b0;

        result.result_kind    = mrc_pkg::KIND_REGISTER;
        result.reg_index      = d[7:1];
        result.reg_value      = {held_next, rx};
        result.status         = mrc_pkg::ST_OK;
        result.exception_code = 8'd0;

        // Final status of the frame, in priority order.
        if (crc_next != {rx, crc_low_next})
        begin
            final_status = mrc_pkg::ST_CRC;
        end
        else if (exc_seen_next)
        begin
            final_status = mrc_pkg::ST_EXCEPTION;
        end
        else if (flags_next[mrc_pkg::FLAG_ADDR])
        begin
            final_status = mrc_pkg::ST_ADDRESS;
        end
        else if (flags_next[mrc_pkg::FLAG_FUNC])
        begin
            final_status = mrc_pkg::ST_FUNCTION;
        end
        else if (flags_next[mrc_pkg::FLAG_COUNT])
        begin
            final_status = mrc_pkg::ST_COUNT;
        end
        else if (flags_next[mrc_pkg::FLAG_RANGE])
        begin
            final_status = mrc_pkg::ST_RANGE;
        end
        else
        begin
            final_status = mrc_pkg::ST_OK;
        end

        if (!frame_open)
        begin
            // Stray byte outside a frame: no state change, no result.
            crc_next      = crc_reg;
            exc_seen_next = exc_seen_reg;
        end
        else if (p_plus2 < {1'b0, frame_len})
        begin
            // Body byte: check it and fold it into the CRC.
            if (p == 8'd0)
            begin
                if (rx != expected_slave_reg)
                begin
                    flags_next[mrc_pkg::FLAG_ADDR] = 1'b1;
                end
            end
            else if (p == 8'd1)
            begin
                if (!exc_seen_next && rx != (transaction_type_reg ? mrc_pkg::FC_WRITE
                                                                  : mrc_pkg::FC_READ))
                begin
                    flags_next[mrc_pkg::FLAG_FUNC] = 1'b1;
                end
            end
            else if (exc_seen_next)
            begin
                if (p == 8'd2)
                begin
                    exc_byte_next = rx;
                end
            end
            else if (!transaction_type_reg)
            begin
                if (p == 8'd2)
                begin
                    if (rx != {nreg, 1'b0} || expected_count_reg > MaxRegs)
                    begin
                        flags_next[mrc_pkg::FLAG_COUNT] = 1'b1;
                    end
                end
                else if (!d[0])
                begin
                    held_next = rx;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            else
            begin
                if (p == 8'd2 || p == 8'd4)
                begin
                    held_next = rx;
                end
                else if (p == 8'd3)
                begin
                    if ({held_next, rx} != expected_offset_reg)
                    begin
                        flags_next[mrc_pkg::FLAG_RANGE] = 1'b1;
                    end
                end
                else if (p == 8'd5)
                begin
                    if ({held_next, rx} != {9'd0, expected_count_reg})
                    begin
                        flags_next[mrc_pkg::FLAG_RANGE] = 1'b1;
                    end
                end
            end
            crc_next      = mrc_pkg::crc_add(crc_next, rx);
            byte_pos_next = p + 8'd1;
        end
        else if (p_plus2 == {1'b0, frame_len})
        begin
            // First CRC byte, low half of the received CRC.
            crc_low_next  = rx;
            byte_pos_next = p + 8'd1;
        end
        else
        begin
            // Second CRC byte: report and close the frame.
            emit                  = 1'b1;
            result.result_kind    = mrc_pkg::KIND_STATUS;
            result.reg_index      = 7'd0;
            result.reg_value      = 16'd0;
            result.status         = final_status;
            result.exception_code = (final_status == mrc_pkg::ST_EXCEPTION) ? exc_byte_next
                                                                            : 8'd0;
            byte_pos_next = 8'd0;
            crc_next      = mrc_pkg::CRC_INIT;
            exc_seen_next = 1'b0;
            flags_next    = 4'd0;
            held_next     = 8'd0;
            exc_byte_next = 8'd0;
            crc_low_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= 8'd0;
            crc_reg      <= mrc_pkg::CRC_INIT;
            exc_seen_reg <= 1'b0;
            flags_reg    <= 4'd0;
            held_reg     <= 8'd0;
            exc_byte_reg <= 8'd0;
            crc_low_reg  <= 8'd0;
        end
        else if (stage_fire)
        begin
            byte_pos_reg <= byte_pos_next;
            crc_reg      <= crc_next;
            exc_seen_reg <= exc_seen_next;
            flags_reg    <= flags_next;
            held_reg     <= held_next;
            exc_byte_reg <= exc_byte_next;
            crc_low_reg  <= crc_low_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
`include "modbus_rtu_response_checker_assert.svh"

    `MRC_ASSERT(a_stall_only_when_blocked, clk, rst_n,
        in_stall |-> (stage_valid_reg && out_valid_reg && out_stall),
        "input stalled without a blocked result")
    `MRC_ASSERT(a_status_closes_frame, clk, rst_n,
        (stage_fire && emit && result.result_kind == mrc_pkg::KIND_STATUS)
            |=> (byte_pos_reg == 8'd0),
        "frame still open after its final status")
    `MRC_ASSERT(a_exc_code_only_on_exception, clk, rst_n,
        (out_valid && out_data.exception_code != 8'd0)
            |-> (out_data.status == mrc_pkg::ST_EXCEPTION),
        "exception code on a non-exception result")
    // The position may still be unset at the first edge of reset.
    `MRC_ASSERT_ALWAYS(a_position_in_range, clk,
        !rst_n || byte_pos_reg != 8'hFF,
        "byte position past the longest frame")

endmodule

`default_nettype wire

// ===== verif/modbus_rtu_response_checker_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Feeds slave replies byte by byte, predicts every register and frame status
// in a local model of the checker, and compares each result item in order.
// ---------------------------------------------------------------------------

module modbus_rtu_response_checker_tb;

    localparam int READ_REG_LIMIT   = mrc_pkg::MAX_READ_REGS_DEF;
    localparam int PHASES           = 12;
    localparam int PHASE_BYTES      = 90;
    // Two pipeline stages sit between input and result; a few spare cycles
    // cover any item still in flight that causes no result.
    localparam int LATENCY_SLACK    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    // Cycles without any accepted item or result before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    mrc_pkg::in_item_t   in_data = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    mrc_pkg::out_item_t  out_data;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_response_checker #(
        .MAX_READ_REGS(READ_REG_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bytes waiting to be offered, and the results the model says are owed.
    mrc_pkg::in_item_t    byte_queue[$];
    mrc_pkg::out_item_t   results_due[$];
    mrc_pkg::out_item_t   oldest_due;
    // Bytes queued or on the wire but not yet taken by the checker.
    int          bytes_outstanding = 0;
    int          fault_count = 0;
    int          phase_bytes = 0;
    int          quiet_cycles = 0;

    // Idling knobs, set per phase by the stimulus process.
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          long_hold_armed = 1'b0;
    int          hold_left = 0;

    // Mirror of the configuration registers, reset values included.
    logic [7:0]  cfg_slave = 8'd1;
    logic        cfg_write = 1'b0;
    logic [6:0]  cfg_count = 7'd1;
    logic [15:0] cfg_offset = 16'h0000;

    // Model of the reply in progress.
    logic [7:0]  reply_pos = 8'd0;
    logic [15:0] reply_crc = mrc_pkg::CRC_INIT;
    logic        reply_exc = 1'b0;
    logic [3:0]  reply_flags = 4'd0;
    logic [7:0]  reply_held = 8'd0;
    logic [7:0]  reply_exc_code = 8'd0;
    logic [7:0]  reply_crc_lo = 8'd0;

    // Scratch buffer for one reply frame while it is being composed.
    logic [7:0]  frame_buf[$];

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        int k;
        acc = crc ^ {8'h00, data};
        for (k = 0; k < 8; k++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ mrc_pkg::CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // A count above the limit still sizes the frame at the limit.
    function automatic int read_regs_in_force();
        return (cfg_count > READ_REG_LIMIT) ? READ_REG_LIMIT : int'(cfg_count);
    endfunction

    function automatic void clear_reply();
        reply_pos      = 8'd0;
        reply_crc      = mrc_pkg::CRC_INIT;
        reply_exc      = 1'b0;
        reply_flags    = 4'd0;
        reply_held     = 8'd0;
        reply_exc_code = 8'd0;
        reply_crc_lo   = 8'd0;
    endfunction

    // Advances the reply model by one accepted byte and records any result
    // the checker owes for it.
    function automatic void judge_reply_byte(input mrc_pkg::in_item_t it);
        logic [7:0] rx;
        int p;
        int nreg;
        int span;
        int d;
        logic [2:0] st;
        mrc_pkg::out_item_t res;
        rx = it.rx_byte;
        if (it.frame_start)
        begin
            clear_reply();
        end
        else if (reply_pos == 8'd0)
        begin
            // A byte outside any frame is dropped.
            return;
        end
        p = reply_pos;
        nreg = read_regs_in_force();
        if (p == 1 && rx[7])
        begin
            reply_exc = 1'b1;
        end
        span = reply_exc ? 5 : (cfg_write ? 8 : 5 + 2 * nreg);
        if (p + 2 < span)
        begin
            if (p == 0)
            begin
                if (rx != cfg_slave)
                begin
                    reply_flags[mrc_pkg::FLAG_ADDR] = 1'b1;
                end
            end
            else if (p == 1)
            begin
                if (!reply_exc && rx != (cfg_write ? mrc_pkg::FC_WRITE : mrc_pkg::FC_READ))
                begin
                    reply_flags[mrc_pkg::FLAG_FUNC] = 1'b1;
                end
            end
            else if (reply_exc)
            begin
                if (p == 2)
                begin
                    reply_exc_code = rx;
                end
            end
            else if (!cfg_write)
            begin
                if (p == 2)
                begin
                    if (int'(rx) != 2 * nreg || cfg_count > READ_REG_LIMIT)
                    begin
                        reply_flags[mrc_pkg::FLAG_COUNT] = 1'b1;
                    end
                end
                else
                begin
                    d = p - 3;
                    if (d[0] == 1'b0)
                    begin
                        reply_held = rx;
                    end
                    else
                    begin
                        res.result_kind    = mrc_pkg::KIND_REGISTER;
                        res.reg_index      = 7'(d >> 1);
                        res.reg_value      = {reply_held, rx};
                        res.status         = mrc_pkg::ST_OK;
                        res.exception_code = 8'h00;
                        results_due.push_back(res);
                    end
                end
            end
            else
            begin
                if (p == 2 || p == 4)
                begin
                    reply_held = rx;
                end
                else if (p == 3)
                begin
                    if ({reply_held, rx} != cfg_offset)
                    begin
                        reply_flags[mrc_pkg::FLAG_RANGE] = 1'b1;
                    end
                end
                else if (p == 5)
                begin
                    if ({reply_held, rx} != {9'h000, cfg_count})
                    begin
                        reply_flags[mrc_pkg::FLAG_RANGE] = 1'b1;
                    end
                end
            end
            reply_crc = crc16_modbus_byte(reply_crc, rx);
            reply_pos = reply_pos + 8'd1;
        end
        else if (p + 2 == span)
        begin
            reply_crc_lo = rx;
            reply_pos = reply_pos + 8'd1;
        end
        else
        begin
            // CRC high byte closes the frame.
            if (reply_crc != {rx, reply_crc_lo})
                st = mrc_pkg::ST_CRC;
            else if (reply_exc)
                st = mrc_pkg::ST_EXCEPTION;
            else if (reply_flags[mrc_pkg::FLAG_ADDR])
                st = mrc_pkg::ST_ADDRESS;
            else if (reply_flags[mrc_pkg::FLAG_FUNC])
                st = mrc_pkg::ST_FUNCTION;
            else if (reply_flags[mrc_pkg::FLAG_COUNT])
                st = mrc_pkg::ST_COUNT;
            else if (reply_flags[mrc_pkg::FLAG_RANGE])
                st = mrc_pkg::ST_RANGE;
            else
                st = mrc_pkg::ST_OK;
            res.result_kind    = mrc_pkg::KIND_STATUS;
            res.reg_index      = 7'd0;
            res.reg_value      = 16'h0000;
            res.status         = st;
            res.exception_code = (st == mrc_pkg::ST_EXCEPTION) ? reply_exc_code : 8'h00;
            results_due.push_back(res);
            clear_reply();
        end
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            fault_count++;
        end
    endfunction

    function automatic void offer_byte(input logic [7:0] b, input logic start);
        mrc_pkg::in_item_t it;
        it.rx_byte     = b;
        it.frame_start = start;
        byte_queue.push_back(it);
        bytes_outstanding++;
    endfunction

    // Pushes the first keep bytes of the composed frame; the first one opens it.
    function automatic void emit_frame(input int keep);
        int i;
        for (i = 0; i < keep && i < frame_buf.size(); i++)
        begin
            offer_byte(frame_buf[i], i == 0);
        end
        phase_bytes += keep;
    endfunction

    // Random bytes, mostly outside any frame; now and then one opens a junk frame.
    function automatic void emit_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            offer_byte(8'($urandom_range(0, 255)), chance(15));
        end
    endfunction

    function automatic void seal_frame(input bit bad_crc);
        logic [15:0] c;
        int i;
        c = mrc_pkg::CRC_INIT;
        for (i = 0; i < frame_buf.size(); i++)
        begin
            c = crc16_modbus_byte(c, frame_buf[i]);
        end
        if (bad_crc)
        begin
            c = c ^ 16'($urandom_range(1, 16'hFFFF));
        end
        // The CRC goes out low byte first.
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endfunction

    function automatic logic [7:0] wrong_function(input logic [7:0] good);
        logic [7:0] fc;
        fc = 8'($urandom_range(0, 127));
        if (fc == good)
        begin
            fc = fc ^ 8'h01;
        end
        return fc;
    endfunction

    // Builds a reply sized for the current setting. Each checked field is
    // broken with probability fault percent, the CRC included.
    function automatic void compose_reply(input bit as_exception, input int fault);
        logic [15:0] word;
        logic [7:0] count_byte;
        int nreg;
        int r;
        frame_buf.delete();
        frame_buf.push_back(chance(fault) ? cfg_slave ^ (8'h01 << $urandom_range(0, 7))
                                          : cfg_slave);
        if (as_exception)
        begin
            frame_buf.push_back(8'h80 | 8'($urandom_range(0, 127)));
            frame_buf.push_back(chance(25) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        else if (cfg_write)
        begin
            frame_buf.push_back(chance(fault) ? wrong_function(mrc_pkg::FC_WRITE)
                                              : mrc_pkg::FC_WRITE);
            word = cfg_offset;
            if (chance(fault))
            begin
                word = word ^ (16'h0001 << $urandom_range(0, 15));
            end
            frame_buf.push_back(word[15:8]);
            frame_buf.push_back(word[7:0]);
            word = {9'h000, cfg_count};
            if (chance(fault))
            begin
                word = word ^ (16'h0001 << $urandom_range(0, 15));
            end
            frame_buf.push_back(word[15:8]);
            frame_buf.push_back(word[7:0]);
        end
        else
        begin
            nreg = read_regs_in_force();
            frame_buf.push_back(chance(fault) ? wrong_function(mrc_pkg::FC_READ)
                                              : mrc_pkg::FC_READ);
            count_byte = 8'(2 * nreg);
            if (chance(fault))
            begin
                count_byte = count_byte ^ (8'h01 << $urandom_range(0, 7));
            end
            frame_buf.push_back(count_byte);
            for (r = 0; r < 2 * nreg; r++)
            begin
                frame_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        seal_frame(chance(fault));
    endfunction

    // Mostly well-formed replies with random content; the rest are exception
    // replies, frames cut short by the next start, and loose noise bytes.
    function automatic void add_random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            compose_reply(1'b0, 8);
            emit_frame(frame_buf.size());
        end
        else if (r < 82)
        begin
            compose_reply(1'b1, 8);
            emit_frame(frame_buf.size());
        end
        else if (r < 91)
        begin
            compose_reply(chance(20), 0);
            emit_frame($urandom_range(1, frame_buf.size() - 1));
        end
        else
        begin
            emit_noise($urandom_range(1, 4));
        end
    endfunction

    // One APB write: setup cycle, then the access cycle that commits it.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mrc_pkg::REG_EXPECTED_SLAVE:   cfg_slave  = value[7:0];
            mrc_pkg::REG_TRANSACTION_TYPE: cfg_write  = value[0];
            mrc_pkg::REG_EXPECTED_COUNT:   cfg_count  = value[6:0];
            mrc_pkg::REG_EXPECTED_OFFSET:  cfg_offset = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] slave, input logic wr,
                                 input logic [6:0] count, input logic [15:0] offset);
        write_register(mrc_pkg::REG_EXPECTED_SLAVE, {24'h0, slave});
        write_register(mrc_pkg::REG_TRANSACTION_TYPE, {31'h0, wr});
        write_register(mrc_pkg::REG_EXPECTED_COUNT, {25'h0, count});
        write_register(mrc_pkg::REG_EXPECTED_OFFSET, {16'h0, offset});
    endtask

    // Waits until every queued byte is taken and every owed result has come,
    // then lets slack more cycles pass for items that cause no result.
    task automatic settle(input int slack);
        while (bytes_outstanding != 0 || results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (slack) @(posedge clk);
    endtask

    // Driver: offers queued bytes, holds a stalled item steady, and hands
    // each accepted item to the model.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                judge_reply_byte(in_data);
                bytes_outstanding--;
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_data  <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest owed one and
    // drives out_stall, including one long hold-off that backs up the input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, out_data);
                    fault_count++;
                end
                else
                begin
                    oldest_due = results_due.pop_front();
                    check_field("result_kind", oldest_due.result_kind, out_data.result_kind);
                    check_field("reg_index", oldest_due.reg_index, out_data.reg_index);
                    check_field("reg_value", oldest_due.reg_value, out_data.reg_value);
                    check_field("status", oldest_due.status, out_data.status);
                    check_field("exception_code", oldest_due.exception_code,
                                out_data.exception_code);
                end
            end
            if (long_hold_armed && out_valid)
            begin
                long_hold_armed = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Watchdog: a correct run never goes this long without taking an item or a result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset setting (slave 1, read of one register).
        // A clean read reply.
        compose_reply(1'b0, 0);
        emit_frame(frame_buf.size());
        // An exception reply whose exception byte is zero.
        frame_buf.delete();
        frame_buf.push_back(8'h01);
        frame_buf.push_back(mrc_pkg::FC_READ | 8'h80);
        frame_buf.push_back(8'h00);
        seal_frame(1'b0);
        emit_frame(frame_buf.size());
        // A stray byte while no frame is open must be dropped.
        offer_byte(8'hA5, 1'b0);
        // A reply cut short and abandoned by the next start, which has a bad CRC.
        compose_reply(1'b0, 0);
        emit_frame(3);
        compose_reply(1'b0, 0);
        frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h80;
        emit_frame(frame_buf.size());
        settle(LATENCY_SLACK);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:  apply_setting(8'h00, 1'b0, 7'd2, 16'h0000);
                1:  apply_setting(8'hFF, 1'b1, 7'd125, 16'hFFFF);
                2:  apply_setting(8'($urandom), 1'b0, 7'd0, 16'($urandom));
                3:  apply_setting(8'($urandom), 1'b1, 7'd0, 16'h0000);
                4:  apply_setting(8'($urandom), 1'b0, 7'd127, 16'($urandom));
                5:  apply_setting(8'($urandom), 1'b1, 7'($urandom_range(1, 124)),
                                  16'($urandom));
                6:  apply_setting(8'($urandom), 1'b0, 7'd3, 16'($urandom));
                7:  apply_setting(8'($urandom), 1'b0, 7'd125, 16'($urandom));
                8:  apply_setting(8'($urandom), 1'b1, 7'd127, 16'($urandom));
                9:  apply_setting(8'($urandom), 1'b0, 7'($urandom_range(1, 5)),
                                  16'($urandom));
                10: apply_setting(8'($urandom), 1'b0, 7'd126, 16'hFFFF);
                default: apply_setting(8'($urandom), 1'b0, 7'd1, 16'($urandom));
            endcase

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 26;
                    recv_stall_pct = 26;
                end
            endcase

            // In the first phase the receiver sits on a result for a long
            // stretch while the sender keeps offering, so the input backs up.
            if (ph == 0)
            begin
                long_hold_armed = 1'b1;
            end

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                add_random_frame();
                // Halfway through one phase the sender waits for every owed
                // result before it goes on.
                if (ph == 6 && phase_bytes >= PHASE_BYTES / 2 && phase_bytes < PHASE_BYTES)
                begin
                    settle(0);
                    phase_bytes = PHASE_BYTES;
                    add_random_frame();
                end
            end
            settle(LATENCY_SLACK);
        end

        if (fault_count == 0 && results_due.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
